>>> design/mted_pkg.sv
// ----------------------------------------------------------------------------
// mted_pkg: shared types and constants of the expert dispatch core
// Holds the controller states, the command and status bundles and the codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package mted_pkg;

  localparam int unsigned LOCAL_SLOTS        = 8;
  localparam int unsigned MAX_K              = 8;
  localparam int unsigned MAX_TOKENS         = 4096;
  localparam int unsigned DIV_W              = 12;
  localparam int unsigned IN_W               = 56;
  localparam int unsigned OUT_W              = 96;
  localparam int unsigned CFG_W              = 13;
  localparam int unsigned CFG_IDX_W          = 3;

  // Transaction kinds carried on the input tuser
  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_SEL   = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;
  localparam logic [1:0] MODE_CLEAR = 2'd3;

  // Replicate grouping codes
  localparam logic [1:0] AXIS_ROWS = 2'd1;
  localparam logic [1:0] AXIS_COLS = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_DEVICE_COORD = 3'd0;
  localparam logic [2:0] CFG_MESH_ROWS    = 3'd1;
  localparam logic [2:0] CFG_MESH_COLS    = 3'd2;
  localparam logic [2:0] CFG_TOKENS_PER   = 3'd3;
  localparam logic [2:0] CFG_AXIS_MODE    = 3'd4;
  localparam logic [2:0] CFG_K_VALUE      = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_TOK,
    ST_LOAD_COORD,
    ST_DIV_COORD,
    ST_SDEV,
    ST_MAP_RD,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic accept;
    logic div_step;
    logic start_coord;
    logic calc_sdev;
    logic map_rd;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       div_last;
    logic       out_free;
  } sts_t;

endpackage
`default_nettype wire

>>> design/mted_ctrl.sv
// ----------------------------------------------------------------------------
// mted_ctrl: sequencing state machine
// Steps a selection through divide, device derivation, map read, result; a query goes straight to result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module mted_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire mted_pkg::sts_t sts_i,
  output mted_pkg::cmd_t     cmd_o
);

  mted_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mted_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mted_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          if (sts_i.mode == mted_pkg::MODE_SEL) begin
            state_d = mted_pkg::ST_DIV_TOK;
          end else if (sts_i.mode == mted_pkg::MODE_QUERY) begin
            state_d = mted_pkg::ST_RESULT;
          end
        end
      end
      mted_pkg::ST_DIV_TOK: begin
        if (sts_i.div_last) state_d = mted_pkg::ST_LOAD_COORD;
      end
      mted_pkg::ST_LOAD_COORD: state_d = mted_pkg::ST_DIV_COORD;
      mted_pkg::ST_DIV_COORD: begin
        if (sts_i.div_last) state_d = mted_pkg::ST_SDEV;
      end
      mted_pkg::ST_SDEV:   state_d = mted_pkg::ST_MAP_RD;
      mted_pkg::ST_MAP_RD: state_d = mted_pkg::ST_RESULT;
      mted_pkg::ST_RESULT: begin
        if (sts_i.out_free) state_d = mted_pkg::ST_IDLE;
      end
      default: state_d = mted_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    case (state_q)
      mted_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        cmd_o.accept  = s_axis_tvalid;
      end
      mted_pkg::ST_DIV_TOK, mted_pkg::ST_DIV_COORD: cmd_o.div_step = 1'b1;
      mted_pkg::ST_LOAD_COORD: cmd_o.start_coord = 1'b1;
      mted_pkg::ST_SDEV:       cmd_o.calc_sdev   = 1'b1;
      mted_pkg::ST_MAP_RD:     cmd_o.map_rd      = 1'b1;
      mted_pkg::ST_RESULT:     cmd_o.commit      = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule
`default_nettype wire

>>> design/mted_dp.sv
// ----------------------------------------------------------------------------
// mted_dp: dispatch datapath
// Configuration, serial divider, owner map memory, local list, counts, output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module mted_dp (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [mted_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [mted_pkg::CFG_W-1:0]          cfg_wdata_i,
  input  wire logic [mted_pkg::IN_W-1:0]           s_axis_tdata,
  input  wire logic [1:0]                          s_axis_tuser,
  input  wire mted_pkg::cmd_t                      cmd_i,
  output mted_pkg::sts_t                           sts_o,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  output logic [mted_pkg::OUT_W-1:0]               m_axis_tdata
);

  localparam int unsigned EPD = mted_pkg::LOCAL_SLOTS;
  localparam int unsigned DW  = mted_pkg::DIV_W;

  // Configuration registers
  logic [5:0]  coord_q;
  logic [6:0]  cols_q;
  logic [12:0] tpd_q;
  logic [1:0]  axis_q;
  logic [3:0]  kval_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coord_q <= '0;
      cols_q  <= 7'd1;
      tpd_q   <= 13'd1;
      axis_q  <= '0;
      kval_q  <= 4'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mted_pkg::CFG_DEVICE_COORD: coord_q <= cfg_wdata_i[5:0];
        // Mesh row count takes no part in routing
        mted_pkg::CFG_MESH_ROWS:    ;
        mted_pkg::CFG_MESH_COLS:    cols_q  <= cfg_wdata_i[6:0];
        mted_pkg::CFG_TOKENS_PER:   tpd_q   <= cfg_wdata_i;
        mted_pkg::CFG_AXIS_MODE:    axis_q  <= cfg_wdata_i[1:0];
        mted_pkg::CFG_K_VALUE:      kval_q  <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  // Input fields
  logic [1:0]  in_mode;
  logic [5:0]  in_src, in_owner;
  logic [7:0]  in_expert;
  logic [11:0] in_token;
  assign in_mode   = s_axis_tuser;
  assign in_src    = s_axis_tdata[5:0];
  assign in_owner  = s_axis_tdata[11:6];
  assign in_expert = s_axis_tdata[19:12];
  assign in_token  = s_axis_tdata[31:20];

  // Latched item
  logic [1:0]  mode_q;
  logic [7:0]  expert_q;
  logic [11:0] token_q;
  logic [2:0]  kslot_q;
  logic [15:0] score_q;
  logic [2:0]  qslot_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mode_q   <= in_mode;
      expert_q <= in_expert;
      token_q  <= in_token;
      kslot_q  <= s_axis_tdata[34:32];
      score_q  <= s_axis_tdata[50:35];
      qslot_q  <= s_axis_tdata[53:51];
    end
  end

  // Serial restoring divider, one quotient bit a cycle
  logic [DW-1:0] dvd_q;
  logic [12:0]   rem_q;
  logic [12:0]   dsr_q;
  logic [3:0]    cnt_q;
  logic [13:0]   trial;
  logic          qbit;
  logic          start_tok;
  logic [11:0]   grp_q;

  assign start_tok = cmd_i.accept && (in_mode == mted_pkg::MODE_SEL);
  assign trial     = {rem_q, dvd_q[DW-1]};
  assign qbit      = (trial >= {1'b0, dsr_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_tok || cmd_i.start_coord) begin
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_tok) begin
      dvd_q <= in_token;
      rem_q <= '0;
      dsr_q <= (tpd_q == 13'd0) ? 13'd1 : tpd_q;
    end else if (cmd_i.start_coord) begin
      grp_q <= dvd_q;
      dvd_q <= {{(DW-6){1'b0}}, coord_q};
      rem_q <= '0;
      dsr_q <= (cols_q == 7'd0) ? 13'd1 : {6'd0, cols_q};
    end else if (cmd_i.div_step) begin
      rem_q <= qbit ? 13'(trial - {1'b0, dsr_q}) : trial[12:0];
      dvd_q <= {dvd_q[DW-2:0], qbit};
    end
  end

  assign sts_o.div_last = (cnt_q == 4'(DW - 1));
  assign sts_o.mode     = in_mode;

  // Source device: one multiply and add after both divisions, or the token group alone in other axis modes
  logic [6:0]  cols_eff;
  logic [11:0] mul_a;
  logic [11:0] add_b;
  logic [19:0] sdev_q;

  assign cols_eff = (cols_q == 7'd0) ? 7'd1 : cols_q;
  assign mul_a    = (axis_q == mted_pkg::AXIS_COLS) ? grp_q : {6'd0, dvd_q[5:0]};
  assign add_b    = (axis_q == mted_pkg::AXIS_COLS) ? {5'd0, rem_q[6:0]} : grp_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_sdev) begin
      if (axis_q == mted_pkg::AXIS_ROWS || axis_q == mted_pkg::AXIS_COLS) begin
        sdev_q <= {8'd0, mul_a} * {13'd0, cols_eff} + {8'd0, add_b};
      end else begin
        sdev_q <= {8'd0, grp_q};
      end
    end
  end

  // Owner map memory: written on load, read once per selection
  logic [5:0] map_mem [64*256];
  logic [5:0] map_rd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && in_mode == mted_pkg::MODE_LOAD) begin
      map_mem[{in_src, in_expert}] <= in_owner;
    end
    if (cmd_i.map_rd) begin
      map_rd_q <= map_mem[{sdev_q[5:0], expert_q}];
    end
  end

  // Local expert list and counts
  logic [7:0]  list_q [EPD];
  logic [3:0]  len_q;
  logic [12:0] cnt_slot_q [EPD];
  logic [12:0] act_q;
  logic        hit_flag_q;

  logic        hit_any;
  logic [2:0]  hit_slot;
  logic [3:0]  effk;
  logic        sel_ok;
  logic        matched;
  logic        tok_end;
  logic [12:0] slot_cnt;
  logic [12:0] query_cnt;
  logic        do_sel;

  always_comb begin
    hit_any  = 1'b0;
    hit_slot = '0;
    for (int e = EPD - 1; e >= 0; e--) begin
      if (4'(e) < len_q && list_q[e] == expert_q) begin
        hit_any  = 1'b1;
        hit_slot = 3'(e);
      end
    end
  end

  assign effk      = (kval_q > 4'(mted_pkg::MAX_K)) ? 4'(mted_pkg::MAX_K) : kval_q;
  assign sel_ok    = ({1'b0, kslot_q} < effk) && (sdev_q[19:6] == '0) &&
                     (map_rd_q == coord_q);
  assign matched   = sel_ok && hit_any;
  assign tok_end   = ({1'b0, kslot_q} + 4'd1 >= effk);
  assign slot_cnt  = cnt_slot_q[hit_slot];
  assign query_cnt = cnt_slot_q[qslot_q];
  assign do_sel    = cmd_i.commit && (mode_q == mted_pkg::MODE_SEL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int e = 0; e < EPD; e++) begin
        list_q[e]     <= '0;
        cnt_slot_q[e] <= '0;
      end
      len_q      <= '0;
      act_q      <= '0;
      hit_flag_q <= 1'b0;
    end else begin
      // Append own experts on load
      if (cmd_i.accept && in_mode == mted_pkg::MODE_LOAD && in_src == coord_q &&
          in_owner == coord_q && len_q < 4'(EPD)) begin
        list_q[len_q[2:0]] <= in_expert;
        len_q              <= len_q + 4'd1;
      end
      // Clear counts
      if (cmd_i.accept && in_mode == mted_pkg::MODE_CLEAR) begin
        for (int e = 0; e < EPD; e++) cnt_slot_q[e] <= '0;
        act_q      <= '0;
        hit_flag_q <= 1'b0;
      end
      // Advance counts on a selection
      if (do_sel) begin
        if (matched && !slot_cnt[12]) begin
          cnt_slot_q[hit_slot] <= slot_cnt + 13'd1;
        end
        if (tok_end) begin
          if ((hit_flag_q || matched) && !act_q[12]) act_q <= act_q + 13'd1;
          hit_flag_q <= 1'b0;
        end else if (matched) begin
          hit_flag_q <= 1'b1;
        end
      end
    end
  end

  // Result assembly
  logic [mted_pkg::OUT_W-1:0] res;
  logic [11:0]                pos_sat, row_sat;

  assign pos_sat = slot_cnt[12] ? 12'hFFF : slot_cnt[11:0];
  assign row_sat = act_q[12] ? 12'hFFF : act_q[11:0];

  always_comb begin
    res = '0;
    if (mode_q == mted_pkg::MODE_SEL) begin
      res[0]     = matched;
      res[3:1]   = matched ? hit_slot : 3'd0;
      res[15:4]  = matched ? pos_sat : 12'd0;
      res[27:16] = matched ? row_sat : 12'd0;
      res[39:28] = token_q;
      res[42:40] = kslot_q;
      res[58:43] = score_q;
    end else begin
      res[71:59] = query_cnt;
      res[84:72] = act_q;
      res[88:85] = len_q;
    end
  end

  // Output register
  logic                       m_valid_q;
  logic [mted_pkg::OUT_W-1:0] m_data_q;

  assign sts_o.out_free = !m_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) m_data_q <= res;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // Checks
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= 4'(EPD)) else $error("local list overflow");
  a_act_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_q <= 13'(mted_pkg::MAX_TOKENS)) else $error("activated count beyond limit");
  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> (!m_valid_q || m_axis_tready)) else $error("result overwritten");
  a_commit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> m_valid_q) else $error("result not presented");

endmodule
`default_nettype wire

>>> design/moe_token_expert_dispatch_core.sv
// ----------------------------------------------------------------------------
// moe_token_expert_dispatch_core: mixture-of-experts token dispatch
// Routes top-k selections to local experts and keeps per-expert counts.
// ----------------------------------------------------------------------------
// Usage:
//   Input transactions arrive on s_axis; tuser gives the kind (load map entry,
//   selection, query, clear). Loads and clears take effect in the cycle they
//   are accepted and give no result; they can be accepted every cycle.
//   Queries and selections each give one result transaction on m_axis.
//   A query goes from acceptance straight to the result stage and from there
//   into the output register. A selection passes through two 12-step serial
//   divisions (token by tokens per device, then device coordinate by mesh
//   columns) with a coordinate load between them, followed by one multiply-add,
//   one owner-map read and the result stage.
//   One item is in flight at a time; the next is accepted once the current
//   result has been loaded into the output register, even while that result
//   still waits for m_axis_tready. A stalled receiver holds the block in its
//   result stage and s_axis_tready stays low.
//   Reset clears the configuration to its defaults, the local expert list
//   and all counts. The owner map is not cleared and must be loaded first.
//   Configuration is to be written through cfg_we_i/cfg_idx_i/cfg_wdata_i
//   only while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module moe_token_expert_dispatch_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [mted_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [mted_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // src_device[5:0], owner_device[11:6], expert_id[19:12], token_index[31:20],
  // k_slot[34:32], score_in[50:35], query_slot[53:51], zero fill
  input  wire logic [mted_pkg::IN_W-1:0]      s_axis_tdata,
  // mode[1:0]
  input  wire logic [1:0]                     s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // matched[0], local_slot[3:1], list_position[15:4], activation_row[27:16],
  // token_out[39:28], k_out[42:40], score_out[58:43], expert_count[71:59],
  // activated_total[84:72], list_length[88:85], zero fill
  output logic [mted_pkg::OUT_W-1:0]          m_axis_tdata
);

  mted_pkg::cmd_t cmd;
  mted_pkg::sts_t sts;

  mted_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  mted_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
`default_nettype wire

>>> test/tb_moe_token_expert_dispatch_core.sv
// ----------------------------------------------------------------------------
// tb_moe_token_expert_dispatch_core: self-checking bench of the dispatch core
// Drives map loads, top-k selections, count queries and clears over the input
// stream, predicts every result with a local model of the routing state and
// compares each output transaction with the predicted one, with random idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_moe_token_expert_dispatch_core;

  localparam logic [1:0] AXIS_NONE = 2'd0;
  localparam logic [1:0] AXIS_RSVD = 2'd3;
  localparam int unsigned N_DEV = 64;
  localparam int unsigned N_EXP = 256;
  localparam int unsigned SETTLE = 40;
  localparam int unsigned N_SLOT = mted_pkg::LOCAL_SLOTS;

  typedef struct {
    logic [1:0]  mode;
    logic [5:0]  src;
    logic [5:0]  owner;
    logic [7:0]  expert;
    logic [11:0] token;
    logic [2:0]  kslot;
    logic [15:0] score;
    logic [2:0]  qslot;
  } item_t;

  // Fields from the top bit down, matching the output tdata layout
  typedef struct packed {
    logic [3:0]  list_length;
    logic [12:0] activated_total;
    logic [12:0] expert_count;
    logic [15:0] score_out;
    logic [2:0]  k_out;
    logic [11:0] token_out;
    logic [11:0] activation_row;
    logic [11:0] list_position;
    logic [2:0]  local_slot;
    logic        matched;
  } dispatch_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [mted_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [mted_pkg::CFG_W-1:0] cfg_wdata_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [mted_pkg::IN_W-1:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [mted_pkg::OUT_W-1:0] m_axis_tdata;

  moe_token_expert_dispatch_core uut (.*);

  // Predicted routing state
  logic [5:0]  cur_coord;
  logic [6:0]  cur_cols;
  logic [12:0] cur_tpd;
  logic [1:0]  cur_axis;
  logic [3:0]  cur_k;
  logic [5:0]  owner_of [N_DEV*N_EXP];
  bit          owner_known [N_DEV*N_EXP];
  logic [7:0]  local_list [N_SLOT];
  int unsigned list_len;
  int unsigned slot_count [N_SLOT];
  int unsigned active_count;
  bit          token_hit;

  dispatch_res_t pending_results[$];
  bit idling_on = 1'b1;
  int errors = 0;
  int n_sel = 0, n_hit = 0, n_query = 0, n_load = 0;
  int unsigned n_items = 0;
  int rx_stall = 0;

  initial forever #10 clk_i = ~clk_i;

  initial begin
    #25_000_000;
    $display("moe_token_expert_dispatch_core: mismatch");
    $finish;
  end

  function automatic int unsigned eff_k();
    return (cur_k > mted_pkg::MAX_K) ? mted_pkg::MAX_K : {28'd0, cur_k};
  endfunction

  function automatic int unsigned source_of_token(input int unsigned tok);
    int unsigned tpd, cols, grp;
    tpd = (cur_tpd == 13'd0) ? 1 : {19'd0, cur_tpd};
    cols = (cur_cols == 7'd0) ? 1 : {25'd0, cur_cols};
    grp = tok / tpd;
    if (cur_axis == mted_pkg::AXIS_ROWS) return ({26'd0, cur_coord} / cols) * cols + grp;
    if (cur_axis == mted_pkg::AXIS_COLS) return grp * cols + {26'd0, cur_coord} % cols;
    return grp;
  endfunction

  function automatic int unsigned sat_row(input int unsigned v);
    return (v < mted_pkg::MAX_TOKENS) ? v : mted_pkg::MAX_TOKENS - 1;
  endfunction

  // Advance the predicted state by one accepted transaction
  task automatic predict_dispatch(input item_t it);
    dispatch_res_t r;
    int unsigned sd, ek;
    r = '0;
    case (it.mode)
      mted_pkg::MODE_LOAD: begin
        owner_of[it.src*N_EXP + it.expert] = it.owner;
        owner_known[it.src*N_EXP + it.expert] = 1'b1;
        if (it.src == cur_coord && it.owner == cur_coord && list_len < N_SLOT) begin
          local_list[list_len] = it.expert;
          list_len++;
        end
        n_load++;
      end
      mted_pkg::MODE_CLEAR: begin
        foreach (slot_count[i]) slot_count[i] = 0;
        active_count = 0;
        token_hit = 1'b0;
      end
      mted_pkg::MODE_QUERY: begin
        r.expert_count = 13'(slot_count[it.qslot]);
        r.activated_total = 13'(active_count);
        r.list_length = 4'(list_len);
        pending_results.push_back(r);
        n_query++;
      end
      default: begin
        ek = eff_k();
        sd = source_of_token({20'd0, it.token});
        r.token_out = it.token;
        r.k_out = it.kslot;
        r.score_out = it.score;
        if (it.kslot < ek && sd < N_DEV && owner_of[sd*N_EXP + it.expert] == cur_coord) begin
          for (int e = 0; e < int'(list_len); e++) begin
            if (local_list[e] == it.expert) begin
              r.matched = 1'b1;
              r.local_slot = 3'(e);
              r.list_position = 12'(sat_row(slot_count[e]));
              r.activation_row = 12'(sat_row(active_count));
              if (slot_count[e] < mted_pkg::MAX_TOKENS) slot_count[e]++;
              token_hit = 1'b1;
              n_hit++;
              break;
            end
          end
        end
        if (it.kslot + 1 >= ek) begin
          if (token_hit && active_count < mted_pkg::MAX_TOKENS) active_count++;
          token_hit = 1'b0;
        end
        pending_results.push_back(r);
        n_sel++;
      end
    endcase
  endtask

  // Offer one transaction, hold it until accepted, then predict
  task automatic send_item(input item_t it);
    int gap;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= it.mode;
    s_axis_tdata <= {2'b00, it.qslot, it.score, it.kslot, it.token, it.expert, it.owner, it.src};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    n_items++;
    predict_dispatch(it);
  endtask

  function automatic item_t noise_item(input logic [1:0] mode);
    item_t it;
    it.mode = mode;
    it.src = 6'($urandom);
    it.owner = 6'($urandom);
    it.expert = 8'($urandom);
    it.token = 12'($urandom);
    it.kslot = 3'($urandom);
    it.score = 16'($urandom);
    it.qslot = 3'($urandom);
    return it;
  endfunction

  task automatic send_load(input logic [5:0] src, input logic [5:0] owner,
                           input logic [7:0] expert);
    item_t it;
    it = noise_item(mted_pkg::MODE_LOAD);
    it.src = src;
    it.owner = owner;
    it.expert = expert;
    send_item(it);
  endtask

  // Selection; an unwritten map entry on its route is loaded first
  task automatic send_sel(input logic [11:0] token, input logic [2:0] kslot,
                          input logic [7:0] expert, input logic [15:0] score);
    item_t it;
    int unsigned sd;
    sd = source_of_token({20'd0, token});
    if (sd < N_DEV && !owner_known[sd*N_EXP + expert])
      send_load(6'(sd), ($urandom_range(0, 3) != 0) ? cur_coord : 6'($urandom), expert);
    it = noise_item(mted_pkg::MODE_SEL);
    it.token = token;
    it.kslot = kslot;
    it.expert = expert;
    it.score = score;
    send_item(it);
  endtask

  task automatic send_query(input logic [2:0] q);
    item_t it;
    it = noise_item(mted_pkg::MODE_QUERY);
    it.qslot = q;
    send_item(it);
  endtask

  task automatic send_clear();
    send_item(noise_item(mted_pkg::MODE_CLEAR));
  endtask

  // Drop valid and wait until every result is in and the core has settled
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // One register write; the caller drops the write enable afterwards
  task automatic cfg_write(input logic [mted_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mted_pkg::CFG_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      mted_pkg::CFG_DEVICE_COORD: cur_coord = val[5:0];
      mted_pkg::CFG_MESH_ROWS:    ;
      mted_pkg::CFG_MESH_COLS:    cur_cols = val[6:0];
      mted_pkg::CFG_TOKENS_PER:   cur_tpd = val;
      mted_pkg::CFG_AXIS_MODE:    cur_axis = val[1:0];
      mted_pkg::CFG_K_VALUE:      cur_k = val[3:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [5:0] coord, input logic [6:0] rows,
                               input logic [6:0] cols, input logic [12:0] tpd,
                               input logic [1:0] axis, input logic [3:0] k);
    wait_drained();
    cfg_write(mted_pkg::CFG_DEVICE_COORD, {7'd0, coord});
    cfg_write(mted_pkg::CFG_MESH_ROWS, {6'd0, rows});
    cfg_write(mted_pkg::CFG_MESH_COLS, {6'd0, cols});
    cfg_write(mted_pkg::CFG_TOKENS_PER, tpd);
    cfg_write(mted_pkg::CFG_AXIS_MODE, {11'd0, axis});
    cfg_write(mted_pkg::CFG_K_VALUE, {9'd0, k});
    cfg_we_i <= 1'b0;
  endtask

  // Receiver: stall in bursts, check each accepted result against the oldest
  always @(posedge clk_i) begin
    dispatch_res_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[$bits(dispatch_res_t)-1:0];
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) begin
            $display("result error, exp: m=%0d slot=%0d pos=%0d row=%0d tok=%0d k=%0d",
                     want.matched, want.local_slot, want.list_position,
                     want.activation_row, want.token_out, want.k_out);
            $display("  exp: score=%h count=%0d total=%0d len=%0d",
                     want.score_out, want.expert_count, want.activated_total,
                     want.list_length);
            $display("  got: m=%0d slot=%0d pos=%0d row=%0d tok=%0d k=%0d",
                     got.matched, got.local_slot, got.list_position,
                     got.activation_row, got.token_out, got.k_out);
            $display("  got: score=%h count=%0d total=%0d len=%0d",
                     got.score_out, got.expert_count, got.activated_total,
                     got.list_length);
          end
        end
      end
    end
    if (rx_stall > 0) begin
      rx_stall <= rx_stall - 1;
      m_axis_tready <= 1'b0;
    end else if (idling_on && $urandom_range(0, 5) == 0) begin
      rx_stall <= $urandom_range(0, 6);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Empty core: every slot reads zero
  task automatic test_reset_counts();
    for (int q = 0; q < int'(N_SLOT); q++) send_query(3'(q));
  endtask

  // Fill the local list, with a duplicate, foreign owners and an overflow
  task automatic test_local_list();
    logic [7:0] exps [9] = '{8'd0, 8'd255, 8'd17, 8'd17, 8'd3, 8'd200, 8'd9, 8'd44, 8'd88};
    apply_setting(6'd5, 7'd8, 7'd8, 13'd16, AXIS_NONE, 4'd2);
    send_load(6'd5, 6'd63, 8'd77);
    send_load(6'd63, 6'd5, 8'd78);
    foreach (exps[i]) send_load(6'd5, 6'd5, exps[i]);
    send_query(3'd0);
  endtask

  // Extremes of token, score and k slot, hits and misses
  task automatic test_directed_select();
    send_sel(12'd0, 3'd0, 8'd0, 16'h0000);
    send_sel(12'd0, 3'd1, 8'd255, 16'hFFFF);
    send_sel(12'd5, 3'd7, 8'd17, 16'h8001);
    send_sel(12'd5, 3'd0, 8'd17, 16'h7FFE);
    send_sel(12'd5, 3'd1, 8'd77, 16'h1234);
    send_sel(12'd4095, 3'd0, 8'd44, 16'hFFFF);
    send_sel(12'd4095, 3'd1, 8'd0, 16'h0);
    send_query(3'd2);
    send_query(3'd7);
    send_clear();
    send_query(3'd2);
  endtask

  // Random mix per setting: mostly whole tokens, some noise
  task automatic random_phase(input int unsigned budget);
    int unsigned start;
    int ek;
    logic [11:0] tok;
    logic [7:0] ex;
    start = n_items;
    while (n_items - start < budget) begin
      if ($urandom_range(0, 4) != 0) begin
        tok = ($urandom_range(0, 1) != 0) ? 12'($urandom_range(0, 4095)) :
                                            12'($urandom_range(0, 255));
        ek = int'(eff_k());
        for (int k = 0; k < ((ek == 0) ? 1 : ek); k++) begin
          ex = (list_len > 0 && $urandom_range(0, 3) != 0) ?
               local_list[$urandom_range(0, list_len - 1)] : 8'($urandom);
          send_sel(tok, (ek == 0) ? 3'($urandom) : 3'(k), ex, 16'($urandom));
        end
      end else begin
        case ($urandom_range(0, 9))
          0: send_clear();
          1, 2, 3: send_query(3'($urandom));
          4, 5, 6: send_load(6'($urandom), 6'($urandom), 8'($urandom));
          default: send_sel(12'($urandom), 3'($urandom), 8'($urandom), 16'($urandom));
        endcase
      end
    end
  endtask

  task automatic test_settings();
    apply_setting(6'd5, 7'd8, 7'd8, 13'd16, AXIS_NONE, 4'd2);
    random_phase(200);
    apply_setting(6'd63, 7'd64, 7'd64, 13'd4096, mted_pkg::AXIS_ROWS, 4'd8);
    random_phase(200);
    apply_setting(6'd0, 7'd1, 7'd1, 13'd1, mted_pkg::AXIS_COLS, 4'd1);
    random_phase(200);
    apply_setting(6'd9, 7'd4, 7'd4, 13'd64, mted_pkg::AXIS_COLS, 4'd4);
    random_phase(200);
    apply_setting(6'd5, 7'd0, 7'd0, 13'd0, AXIS_RSVD, 4'd0);
    random_phase(200);
    apply_setting(6'd12, 7'd127, 7'd127, 13'd8191, mted_pkg::AXIS_ROWS, 4'd15);
    random_phase(200);
    apply_setting(6'd5, 7'd2, 7'd3, 13'd300, mted_pkg::AXIS_ROWS, 4'd3);
    random_phase(200);
    apply_setting(6'd63, 7'd8, 7'd8, 13'd1, mted_pkg::AXIS_COLS, 4'd8);
    random_phase(200);
  endtask

  // Closing stretch with both sides always ready
  task automatic test_no_idle();
    idling_on = 1'b0;
    apply_setting(6'd5, 7'd1, 7'd1, 13'd16, AXIS_NONE, 4'd2);
    send_clear();
    random_phase(150);
    send_query(3'd2);
    send_query(3'd0);
  endtask

  initial begin
    cur_coord = '0; cur_cols = 7'd1; cur_tpd = 13'd1; cur_axis = AXIS_NONE; cur_k = 4'd1;
    list_len = 0; active_count = 0; token_hit = 1'b0;
    foreach (slot_count[i]) slot_count[i] = 0;
    foreach (local_list[i]) local_list[i] = '0;
    foreach (owner_known[i]) owner_known[i] = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_counts();
    test_local_list();
    test_directed_select();
    test_settings();
    test_no_idle();
    wait_drained();
    $display("covered %0d transactions: %0d selections (%0d hits), %0d queries, %0d map loads",
             n_items, n_sel, n_hit, n_query, n_load);
    $display("across eight mesh settings and a closing stretch with no idling");
    if (errors == 0) begin
      $display("moe_token_expert_dispatch_core: match");
    end else begin
      $display("moe_token_expert_dispatch_core: mismatch");
    end
    $finish;
  end

endmodule
